[rtl/core/sbes_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbes_pkg
// Shared types and constants of the spectrum band envelope smoother.
// ----------------------------------------------------------------------------
package sbes_pkg;

    localparam int LEVEL_W     = 20;  // band level, Q4.16
    localparam int RMS_W       = 24;  // frame rms, Q0.24
    localparam int GAIN_W      = 16;  // Q0.16 gains
    localparam int BOUND_W     = 9;   // region boundaries
    localparam int INTENS_W    = 17;  // intensity, Q0.16 with 1.0 included
    localparam int SUM_W       = 25;  // region sum
    localparam int COUNT_W     = 9;   // bands per region
    localparam int POS_W_MAX   = 8;   // band index as carried in the queue
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 72;
    localparam int PROD_W      = LEVEL_W + GAIN_W;

    localparam logic [INTENS_W-1:0] ONE_Q16 = 17'h10000;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_GAIN   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_GAIN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FLOOR_LEVEL   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SILENCE_LEVEL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_BAND_END  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MID_BAND_END  = 3'd5;

    // register reset values
    localparam logic [GAIN_W-1:0]  ATTACK_GAIN_RST   = 16'd45875;
    localparam logic [GAIN_W-1:0]  DECAY_GAIN_RST    = 16'd58982;
    localparam logic [LEVEL_W-1:0] FLOOR_LEVEL_RST   = 20'd7;
    localparam logic [RMS_W-1:0]   SILENCE_LEVEL_RST = 24'd168;
    localparam logic [BOUND_W-1:0] LOW_BAND_END_RST  = 9'd11;
    localparam logic [BOUND_W-1:0] MID_BAND_END_RST  = 9'd24;

    // region codes
    localparam logic [1:0] REGION_LOW  = 2'd0;
    localparam logic [1:0] REGION_MID  = 2'd1;
    localparam logic [1:0] REGION_HIGH = 2'd2;

    typedef struct packed {
        logic [GAIN_W-1:0]  attack_gain;
        logic [GAIN_W-1:0]  decay_gain;
        logic [LEVEL_W-1:0] floor_level;
        logic [RMS_W-1:0]   silence_level;
        logic [BOUND_W-1:0] low_band_end;
        logic [BOUND_W-1:0] mid_band_end;
    } cfg_t;

    // one classified band on its way from front to back
    typedef struct packed {
        logic [LEVEL_W-1:0]   level;
        logic [POS_W_MAX-1:0] pos;
        logic [1:0]           region;
        logic                 silent;
        logic                 last;
    } band_item_t;

endpackage

[rtl/core/sbes_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbes_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sbes_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/sbes_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbes_div
// Restoring divider, one quotient bit per cycle: region sum / band count.
// ----------------------------------------------------------------------------
module sbes_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sbes_pkg::SUM_W-1:0]   dividend,
    input  logic [sbes_pkg::COUNT_W-1:0] divisor,
    output logic                         done,
    output logic [sbes_pkg::SUM_W-1:0]   quotient
);

    localparam int STEP_W = $clog2(sbes_pkg::SUM_W);

    logic [sbes_pkg::COUNT_W-1:0] rem_reg;
    logic [sbes_pkg::SUM_W-1:0]   quo_reg;
    logic [sbes_pkg::COUNT_W-1:0] div_reg;
    logic [STEP_W-1:0]            step_reg;
    logic                         busy_reg;
    logic                         done_reg;

    logic [sbes_pkg::COUNT_W:0]   trial;
    logic                         fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[sbes_pkg::SUM_W-1]};
        fits  = trial >= {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(sbes_pkg::SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits COUNT_W bits
            rem_reg <= fits ? sbes_pkg::COUNT_W'(trial - {1'b0, div_reg})
                            : sbes_pkg::COUNT_W'(trial);
            quo_reg <= {quo_reg[sbes_pkg::SUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/core/sbes_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbes_fifo
// Short flop queue of classified bands between front and back.
// ----------------------------------------------------------------------------
module sbes_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sbes_pkg::band_item_t push_data,
    output logic                 full,
    input  logic                 pop,
    output sbes_pkg::band_item_t pop_data,
    output logic                 empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sbes_pkg::band_item_t slot_reg [DEPTH];
    logic [PTR_W-1:0]     wptr_reg;
    logic [PTR_W-1:0]     rptr_reg;
    logic [CNT_W-1:0]     count_reg;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/sbes_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbes_front
// Accepts band transactions, tracks band position and frame silence, picks
// the region of each band and queues it for the back end.
// ----------------------------------------------------------------------------
module sbes_front #(
    parameter int BAND_COUNT = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sbes_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sbes_pkg::IN_DATA_W-1:0]      in_data,
    output logic                                push,
    output sbes_pkg::band_item_t                push_data,
    input  logic                                fifo_full
);

    localparam int POS_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;

    logic [POS_W-1:0]              pos_reg;
    logic                          silent_reg;
    logic [sbes_pkg::LEVEL_W-1:0]  level;
    logic [sbes_pkg::RMS_W-1:0]    rms;
    logic                          silent;
    logic                          last;
    logic [1:0]                    region;
    logic [sbes_pkg::BOUND_W-1:0]  pos_ext;

    always_comb
    begin
        level   = in_data[sbes_pkg::LEVEL_W-1:0];
        rms     = in_data[sbes_pkg::LEVEL_W +: sbes_pkg::RMS_W];
        pos_ext = sbes_pkg::BOUND_W'(pos_reg);
        // rms only counts with band zero
        silent  = (pos_reg == '0) ? (rms < cfg.silence_level) : silent_reg;
        last    = pos_reg == POS_W'(BAND_COUNT - 1);
        if (pos_ext < cfg.low_band_end)
        begin
            region = sbes_pkg::REGION_LOW;
        end
        else if (pos_ext < cfg.mid_band_end)
        begin
            region = sbes_pkg::REGION_MID;
        end
        else
        begin
            region = sbes_pkg::REGION_HIGH;
        end
        in_ready         = !fifo_full;
        push             = in_valid && !fifo_full;
        push_data.level  = level;
        push_data.pos    = sbes_pkg::POS_W_MAX'(pos_reg);
        push_data.region = region;
        push_data.silent = silent;
        push_data.last   = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            silent_reg <= 1'b0;
        end
        else if (push)
        begin
            pos_reg    <= last ? '0 : pos_reg + 1'b1;
            silent_reg <= silent;
        end
    end

endmodule

[rtl/core/sbes_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbes_back
// Sequencer that runs the envelope blend of each queued band, keeps region
// sums, smooths the region intensities at frame end, and holds the result.
// ----------------------------------------------------------------------------
module sbes_back #(
    parameter int BAND_COUNT = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sbes_pkg::cfg_t                  cfg,
    input  logic                            fifo_empty,
    input  sbes_pkg::band_item_t            head,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sbes_pkg::OUT_DATA_W-1:0] out_data,
    output logic                            out_last
);

    localparam int POS_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
    localparam int LW    = sbes_pkg::LEVEL_W;
    localparam int IW    = sbes_pkg::INTENS_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_STORE = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_DIVW  = 4'd5;
    localparam logic [3:0] S_IPREP = 4'd6;
    localparam logic [3:0] S_IMUL  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]                    state_reg;
    logic [3:0]                    state_next;

    sbes_pkg::band_item_t          item_reg;
    logic [BAND_COUNT-1:0]         env_valid_reg;
    logic [LW-1:0]                 env_reg;
    logic [LW-1:0]                 mul_a_reg;
    logic [sbes_pkg::GAIN_W-1:0]   mul_b_reg;
    logic [LW-1:0]                 base_reg;
    logic [IW-1:0]                 target_reg;
    logic [1:0]                    k_reg;
    logic [sbes_pkg::SUM_W-1:0]    sum_reg   [3];
    logic [sbes_pkg::COUNT_W-1:0]  count_reg [3];
    logic [IW-1:0]                 intens_reg[3];

    logic                          out_valid_reg;
    logic [sbes_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                          out_last_reg;

    logic [LW-1:0]                 ram_rdata;
    logic [POS_W-1:0]              item_pos;
    logic [LW-1:0]                 env_cur;
    logic                          env_rise;
    logic [sbes_pkg::PROD_W-1:0]   prod;
    logic [LW-1:0]                 blend_res;
    logic [LW-1:0]                 env_final;
    logic [LW-2:0]                 env_half;
    logic [IW-1:0]                 norm;
    logic                          ram_we;
    logic                          slot_free;
    logic [IW-1:0]                 intens_cur;
    logic                          intens_rise;
    logic                          div_start;
    logic                          div_done;
    logic [sbes_pkg::SUM_W-1:0]    div_quotient;

    assign item_pos  = item_reg.pos[POS_W-1:0];
    assign slot_free = !out_valid_reg || out_ready;

    sbes_ram #(
        .WIDTH (LW),
        .DEPTH (BAND_COUNT)
    ) u_env_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item_pos),
        .wdata (env_final),
        .raddr (head.pos[POS_W-1:0]),
        .rdata (ram_rdata)
    );

    sbes_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg[k_reg]),
        .divisor  (count_reg[k_reg]),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        // never-written entries read as the reset value zero
        env_cur     = env_valid_reg[item_pos] ? ram_rdata : '0;
        env_rise    = item_reg.level > env_cur;
        // shared multiplier: blend = base + (a * b) >> 16
        prod        = mul_a_reg * mul_b_reg;
        blend_res   = base_reg + prod[sbes_pkg::PROD_W-1:sbes_pkg::GAIN_W];
        env_final   = (item_reg.silent || env_reg < cfg.floor_level) ? '0 : env_reg;
        env_half    = env_final[LW-1:1];
        norm        = ({1'b0, env_half} > LW'(sbes_pkg::ONE_Q16)) ? sbes_pkg::ONE_Q16
                                                                 : IW'(env_half);
        ram_we      = state_reg == S_STORE;
        intens_cur  = intens_reg[k_reg];
        intens_rise = target_reg > intens_cur;
        div_start   = (state_reg == S_DIV) && (count_reg[k_reg] != '0);
        pop         = (state_reg == S_IDLE) && !fifo_empty;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!fifo_empty)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = item_reg.silent ? S_STORE : S_MUL;
            end
            S_MUL:
            begin
                state_next = S_STORE;
            end
            S_STORE:
            begin
                state_next = (item_reg.last && !item_reg.silent) ? S_DIV : S_OUT;
            end
            S_DIV:
            begin
                state_next = div_start ? S_DIVW : S_IPREP;
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    state_next = S_IPREP;
                end
            end
            S_IPREP:
            begin
                state_next = S_IMUL;
            end
            S_IMUL:
            begin
                state_next = (k_reg == sbes_pkg::REGION_HIGH) ? S_OUT : S_DIV;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            env_valid_reg <= '0;
            k_reg         <= sbes_pkg::REGION_LOW;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i]    <= '0;
                count_reg[i]  <= '0;
                intens_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_STORE)
            begin
                env_valid_reg[item_pos] <= 1'b1;
                if (!item_reg.silent)
                begin
                    sum_reg[item_reg.region]   <= sum_reg[item_reg.region]
                                                  + sbes_pkg::SUM_W'(norm);
                    count_reg[item_reg.region] <= count_reg[item_reg.region] + 1'b1;
                end
                if (item_reg.last)
                begin
                    k_reg <= sbes_pkg::REGION_LOW;
                    if (item_reg.silent)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            sum_reg[i]    <= '0;
                            count_reg[i]  <= '0;
                            intens_reg[i] <= '0;
                        end
                    end
                end
            end

            if (state_reg == S_IMUL)
            begin
                intens_reg[k_reg] <= blend_res[IW-1:0];
                if (k_reg == sbes_pkg::REGION_HIGH)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        sum_reg[i]   <= '0;
                        count_reg[i] <= '0;
                    end
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end

            if (state_reg == S_OUT && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head;
        end

        if (state_reg == S_READ)
        begin
            env_reg   <= '0;
            mul_a_reg <= env_rise ? item_reg.level - env_cur : env_cur;
            mul_b_reg <= env_rise ? cfg.attack_gain : cfg.decay_gain;
            base_reg  <= env_rise ? env_cur : '0;
        end
        if (state_reg == S_MUL)
        begin
            env_reg <= blend_res;
        end
        if (state_reg == S_STORE)
        begin
            env_reg <= env_final;
        end

        if (state_reg == S_DIV && !div_start)
        begin
            target_reg <= '0;   // empty region
        end
        if (state_reg == S_DIVW && div_done)
        begin
            target_reg <= div_quotient[IW-1:0];
        end
        if (state_reg == S_IPREP)
        begin
            mul_a_reg <= intens_rise ? LW'(target_reg - intens_cur) : LW'(intens_cur);
            mul_b_reg <= intens_rise ? cfg.attack_gain : cfg.decay_gain;
            base_reg  <= intens_rise ? LW'(intens_cur) : '0;
        end

        if (state_reg == S_OUT && slot_free)
        begin
            out_data_reg <= {1'b0, intens_reg[2], intens_reg[1], intens_reg[0], env_reg};
            out_last_reg <= item_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

[rtl/core/spectrum_band_envelope_smoother.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_band_envelope_smoother
// Attack/decay envelope follower over the bands of a log spectrum frame.
// ----------------------------------------------------------------------------
// Send one transaction per band, bands 0 to BAND_COUNT-1 in order; frame_rms
// is looked at only with band 0, and a frame below silence_level gives zero
// band envelopes and clears the intensities at its last band. Every input
// transaction gives exactly one output transaction with the new band
// envelope and the three region intensities; tlast marks the last band,
// where the intensities are refreshed. The back-end sequencer takes a band
// through queue pop, envelope RAM read, blend multiply, store and output
// register, and takes no new band before it is done with this one; a band
// of a silent frame skips the multiply. The last band of a frame that is not
// silent then runs, for each region that got bands, a divider start, the
// bit-serial sum/count divide, blend setup and blend multiply; an empty
// region skips the divide. A two-entry queue lets the input side take bands
// while the back end works, and the output register holds a finished result
// while the next band is already being taken. The envelope RAM needs no
// clearing pass: per-band valid bits stand in for its reset value.
// ----------------------------------------------------------------------------
module spectrum_band_envelope_smoother #(
    parameter int BAND_COUNT = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [sbes_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sbes_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [19:0] band_level, [43:20] frame_rms, [47:44] zero
    input  logic [sbes_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [19:0] smoothed_level, [36:20] low_intensity, [53:37] mid_intensity,
    // [70:54] high_intensity, [71] zero
    output logic [sbes_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // frame_done
    output logic                               m_axis_tlast
);

    sbes_pkg::cfg_t       cfg_reg;
    sbes_pkg::band_item_t push_data;
    sbes_pkg::band_item_t head;
    logic                 push;
    logic                 pop;
    logic                 fifo_full;
    logic                 fifo_empty;

    // configuration registers; the user must write them only while the block is idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_gain   <= sbes_pkg::ATTACK_GAIN_RST;
            cfg_reg.decay_gain    <= sbes_pkg::DECAY_GAIN_RST;
            cfg_reg.floor_level   <= sbes_pkg::FLOOR_LEVEL_RST;
            cfg_reg.silence_level <= sbes_pkg::SILENCE_LEVEL_RST;
            cfg_reg.low_band_end  <= sbes_pkg::LOW_BAND_END_RST;
            cfg_reg.mid_band_end  <= sbes_pkg::MID_BAND_END_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                sbes_pkg::REG_ATTACK_GAIN:
                begin
                    cfg_reg.attack_gain <= cfg_data[sbes_pkg::GAIN_W-1:0];
                end
                sbes_pkg::REG_DECAY_GAIN:
                begin
                    cfg_reg.decay_gain <= cfg_data[sbes_pkg::GAIN_W-1:0];
                end
                sbes_pkg::REG_FLOOR_LEVEL:
                begin
                    cfg_reg.floor_level <= cfg_data[sbes_pkg::LEVEL_W-1:0];
                end
                sbes_pkg::REG_SILENCE_LEVEL:
                begin
                    cfg_reg.silence_level <= cfg_data[sbes_pkg::RMS_W-1:0];
                end
                sbes_pkg::REG_LOW_BAND_END:
                begin
                    cfg_reg.low_band_end <= cfg_data[sbes_pkg::BOUND_W-1:0];
                end
                sbes_pkg::REG_MID_BAND_END:
                begin
                    cfg_reg.mid_band_end <= cfg_data[sbes_pkg::BOUND_W-1:0];
                end
                default:
                begin
                    // unused index: write ignored
                end
            endcase
        end
    end

    // front: position, silence and region of each band
    sbes_front #(
        .BAND_COUNT (BAND_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .push      (push),
        .push_data (push_data),
        .fifo_full (fifo_full)
    );

    sbes_fifo #(
        .DEPTH (2)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (fifo_empty)
    );

    // back: envelope blend, region sums, frame-end intensities
    sbes_back #(
        .BAND_COUNT (BAND_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .fifo_empty (fifo_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule

[rtl/core/sbes_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbes_checker
// Port-level checks of the envelope smoother, bound to the top level.
// ----------------------------------------------------------------------------
module sbes_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sbes_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);

    logic [9:0] pending_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pending_reg != '0)
        else $error("output transaction without an accepted band");

    a_intens_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[36:20] <= sbes_pkg::ONE_Q16
                          && m_axis_tdata[53:37] <= sbes_pkg::ONE_Q16
                          && m_axis_tdata[70:54] <= sbes_pkg::ONE_Q16)
        else $error("region intensity above 1.0");

endmodule

bind spectrum_band_envelope_smoother sbes_checker u_sbes_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
